// File: hw/rtl/u8d_pkg.sv
// ----------------------------------------------------------------------------
// u8d_pkg: shared types and constants of the UTF-8 byte stream decoder
// Result layout, decoder state and the per-byte decode outcome.
// ----------------------------------------------------------------------------
package u8d_pkg;

  localparam int CP_W          = 21;
  localparam int DEF_FIFO_DEPTH = 4;

  localparam logic [CP_W-1:0] REPLACEMENT_CHAR = 21'h00FFFD;
  localparam logic [CP_W-1:0] END_CODE         = 21'h000000;

  // Lead byte classes
  localparam logic [7:0] LEAD4_MASK  = 8'hF0;
  localparam logic [7:0] LEAD3_MASK  = 8'hE0;
  localparam logic [7:0] LEAD2_MASK  = 8'hC0;
  localparam logic [7:0] CONT_CODE   = 8'h80;

  // Results produced by one byte
  localparam logic [1:0] NRES_NONE = 2'd0;
  localparam logic [1:0] NRES_ONE  = 2'd1;
  localparam logic [1:0] NRES_TWO  = 2'd2;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            end_marker;
    logic            run_final;
  } result_t;

  typedef struct packed {
    logic [1:0]      bytes_pending;
    logic [CP_W-1:0] partial_value;
    logic            string_ended;
  } dec_state_t;

  typedef struct packed {
    dec_state_t state_next;
    logic [1:0] num_results;
    result_t    res0;
    result_t    res1;
  } dec_out_t;

endpackage

// File: hw/rtl/u8d_in_if.sv
// ----------------------------------------------------------------------------
// u8d_in_if: byte channel into the decoder
// Valid/ready channel carrying one buffer byte and its final-byte flag.
// ----------------------------------------------------------------------------
interface u8d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       buffer_last;

  modport source (output valid, output data_byte, output buffer_last, input ready);
  modport sink   (input valid, input data_byte, input buffer_last, output ready);
endinterface

// File: hw/rtl/u8d_out_if.sv
// ----------------------------------------------------------------------------
// u8d_out_if: character channel out of the decoder
// Valid/ready channel carrying one decoded code point or an end marker.
// ----------------------------------------------------------------------------
interface u8d_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic        end_marker;
  logic        run_final;

  modport source (output valid, output code_point, output end_marker,
                  output run_final, input ready);
  modport sink   (input valid, input code_point, input end_marker,
                  input run_final, output ready);
endinterface

// File: hw/rtl/u8d_decode.sv
// ----------------------------------------------------------------------------
// u8d_decode: single-byte decode step
// Works out the results and next state for one byte from the current state.
// ----------------------------------------------------------------------------
module u8d_decode (
  input  logic [7:0]          data_byte,
  input  logic                buffer_last,
  input  u8d_pkg::dec_state_t state,
  output u8d_pkg::dec_out_t   dec
);
  import u8d_pkg::*;

  logic [CP_W-1:0] shifted;
  logic [1:0]      pend_dec;
  logic            has_char;
  logic [CP_W-1:0] char_cp;
  logic            zero_end;
  dec_state_t      nxt;

  assign shifted  = {state.partial_value[CP_W-7:0], data_byte[5:0]};
  assign pend_dec = state.bytes_pending - 2'd1;

  always_comb begin
    nxt      = state;
    has_char = 1'b0;
    char_cp  = REPLACEMENT_CHAR;
    zero_end = 1'b0;
    dec      = '0;

    // Classify the byte against the current state
    priority if (state.string_ended) begin
      if (buffer_last) nxt = '0;
    end else if (state.bytes_pending != 2'd0) begin
      nxt.partial_value = shifted;
      nxt.bytes_pending = pend_dec;
      if (pend_dec == 2'd0) begin
        has_char = 1'b1;
        char_cp  = shifted;
      end else if (buffer_last) begin
        has_char = 1'b1;
      end
    end else if (data_byte == 8'h00) begin
      zero_end = 1'b1;
      if (buffer_last) nxt = '0;
      else nxt.string_ended = 1'b1;
    end else if ((data_byte & LEAD2_MASK) == CONT_CODE) begin
      has_char = 1'b1;
    end else if ((data_byte & LEAD4_MASK) == LEAD4_MASK) begin
      nxt.partial_value = {{(CP_W-3){1'b0}}, data_byte[2:0]};
      nxt.bytes_pending = 2'd3;
    end else if ((data_byte & LEAD3_MASK) == LEAD3_MASK) begin
      nxt.partial_value = {{(CP_W-4){1'b0}}, data_byte[3:0]};
      nxt.bytes_pending = 2'd2;
    end else if ((data_byte & LEAD2_MASK) == LEAD2_MASK) begin
      nxt.partial_value = {{(CP_W-5){1'b0}}, data_byte[4:0]};
      nxt.bytes_pending = 2'd1;
    end else begin
      has_char = 1'b1;
      char_cp  = {{(CP_W-8){1'b0}}, data_byte};
    end

    // Pack the results in order; the final byte closes with an end marker unless a terminator ended the string
    if (zero_end) begin
      dec.num_results = NRES_ONE;
      dec.res0        = '{code_point: END_CODE, end_marker: 1'b1, run_final: 1'b1};
    end else if (!state.string_ended && buffer_last) begin
      if (nxt.bytes_pending != 2'd0 && !has_char) begin
        has_char = 1'b1;
        char_cp  = REPLACEMENT_CHAR;
      end
      nxt = '0;
      if (has_char) begin
        dec.num_results = NRES_TWO;
        dec.res0 = '{code_point: char_cp, end_marker: 1'b0, run_final: 1'b0};
        dec.res1 = '{code_point: END_CODE, end_marker: 1'b1, run_final: 1'b1};
      end else begin
        dec.num_results = NRES_ONE;
        dec.res0 = '{code_point: END_CODE, end_marker: 1'b1, run_final: 1'b1};
      end
    end else if (has_char) begin
      dec.num_results = NRES_ONE;
      dec.res0 = '{code_point: char_cp, end_marker: 1'b0, run_final: 1'b1};
    end else begin
      dec.num_results = NRES_NONE;
    end

    dec.state_next = nxt;
  end

endmodule

// File: hw/rtl/u8d_result_fifo.sv
// ----------------------------------------------------------------------------
// u8d_result_fifo: result queue
// Register queue that takes up to two results per cycle and gives one.
// ----------------------------------------------------------------------------
module u8d_result_fifo #(
  parameter int DEPTH = u8d_pkg::DEF_FIFO_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [1:0]                push_num,
  input  u8d_pkg::result_t          push0,
  input  u8d_pkg::result_t          push1,
  input  logic                      pop,
  output logic                      not_empty,
  output u8d_pkg::result_t          head,
  output logic [$clog2(DEPTH+1)-1:0] level
);
  import u8d_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  result_t         entries [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic [PW-1:0]   wr_ptr_inc;
  logic [PW-1:0]   wr_ptr_inc2;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    if (p == PW'(DEPTH-1)) return '0;
    return p + PW'(1);
  endfunction

  assign wr_ptr_inc  = ptr_inc(wr_ptr);
  assign wr_ptr_inc2 = ptr_inc(wr_ptr_inc);
  assign not_empty   = (count != '0);
  assign head        = entries[rd_ptr];
  assign level       = count;

  // Store incoming results
  always_ff @(posedge clk) begin
    if (push_num != NRES_NONE) entries[wr_ptr] <= push0;
    if (push_num == NRES_TWO) entries[wr_ptr_inc] <= push1;
  end

  // Advance pointers and level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      unique case (push_num)
        NRES_ONE: wr_ptr <= wr_ptr_inc;
        NRES_TWO: wr_ptr <= wr_ptr_inc2;
        default:  wr_ptr <= wr_ptr;
      endcase
      if (pop && not_empty) rd_ptr <= ptr_inc(rd_ptr);
      count <= count + CW'(push_num) - CW'(pop && not_empty);
    end
  end

endmodule

// File: hw/rtl/utf8_byte_stream_decoder.sv
// An accepted byte waits in the input register; its decoded results enter the result queue.
// Throughput: one byte per cycle while the queue has room; a final byte that also gives
// a character or a replacement gives two results, which leave the result queue one by one.
// The input register advances once the queue has room for two results.
// Reset: synchronous, clears decode state, the input register and the queue.
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder: UTF-8 byte stream decoder
// Decodes buffer bytes into code points, replacement characters and end markers.
// ----------------------------------------------------------------------------
module utf8_byte_stream_decoder #(
  parameter int FIFO_DEPTH = u8d_pkg::DEF_FIFO_DEPTH
) (
  input  logic clk,
  input  logic rst,
  u8d_in_if.sink    byte_stream,
  u8d_out_if.source char_stream
);
  import u8d_pkg::*;

  localparam int CW = $clog2(FIFO_DEPTH+1);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       s1_fire;
  dec_state_t state;
  dec_out_t   dec;
  logic [1:0] push_num;
  logic [CW-1:0] level;
  logic       fifo_not_empty;
  result_t    head;

  // Room for the worst case of two results, judged on the registered level
  assign s1_fire           = s1_valid && (level <= CW'(FIFO_DEPTH - 2));
  assign byte_stream.ready = !rst && (!s1_valid || s1_fire);
  assign push_num          = s1_fire ? dec.num_results : NRES_NONE;

  // Hold the accepted byte in the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_stream.ready) begin
      s1_valid <= byte_stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_stream.valid && byte_stream.ready) begin
      s1_byte <= byte_stream.data_byte;
      s1_last <= byte_stream.buffer_last;
    end
  end

  // Advance decode state on each decoded byte
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (s1_fire) begin
      state <= dec.state_next;
    end
  end

  u8d_decode u_decode (
    .data_byte   (s1_byte),
    .buffer_last (s1_last),
    .state       (state),
    .dec         (dec)
  );

  u8d_result_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_num  (push_num),
    .push0     (dec.res0),
    .push1     (dec.res1),
    .pop       (char_stream.ready),
    .not_empty (fifo_not_empty),
    .head      (head),
    .level     (level)
  );

  assign char_stream.valid      = fifo_not_empty;
  assign char_stream.code_point = head.code_point;
  assign char_stream.end_marker = head.end_marker;
  assign char_stream.run_final  = head.run_final;

endmodule

// File: hw/rtl/u8d_checker.sv
// ----------------------------------------------------------------------------
// u8d_checker: port-level checks of the decoder
// Watches the character channel over time; bound to the top level.
// ----------------------------------------------------------------------------
module u8d_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [20:0] out_code_point,
  input logic        out_end_marker,
  input logic        out_run_final
);

  // Stalled transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_code_point)
      && $stable(out_end_marker) && $stable(out_run_final))
    else $error("stalled result transaction changed");

  // An end marker carries no character
  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_end_marker |-> out_code_point == 21'd0)
    else $error("end marker with non-zero code point");

  // An end marker is always the last result of its byte
  a_end_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_end_marker |-> out_run_final)
    else $error("end marker not marked final");

  // Nothing is offered straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind utf8_byte_stream_decoder u8d_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (char_stream.valid),
  .out_ready      (char_stream.ready),
  .out_code_point (char_stream.code_point),
  .out_end_marker (char_stream.end_marker),
  .out_run_final  (char_stream.run_final)
);

// File: sim/tb_utf8_byte_stream_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_byte_stream_decoder: self-checking bench for the UTF-8 byte decoder
// A table of directed bytes is followed by random buffers, mostly well-formed
// UTF-8 with random content, plus cut-off sequences, zero terminators and raw
// noise. An in-bench decoder predicts the characters and end markers, save for directed
// rows with typed-in results. Both sides of the block idle and stall at random.
// ----------------------------------------------------------------------------
module tb_utf8_byte_stream_decoder;
  import u8d_pkg::*;

  localparam int      CLK_HALF     = 6;
  localparam int      RST_CYCLES   = 12;
  localparam int      RANDOM_ITEMS = 600;
  localparam int      MAX_GAP      = 16;
  localparam int      LONG_HOLD    = 400;
  localparam int      HOLD_AFTER   = 150;
  localparam int      DRAIN_CYCLES = 16;
  localparam int      N_DIRECTED   = 26;
  localparam result_t NO_CHAR      = '0;

  // One directed byte; a fixed row carries its results typed in
  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_last;
    logic       fixed;
    logic [1:0] nres;
    result_t    r0;
    result_t    r1;
  } stim_row_t;

  logic clk;
  logic rst;

  u8d_in_if  byte_if ();
  u8d_out_if char_if ();

  utf8_byte_stream_decoder dut (
    .clk         (clk),
    .rst         (rst),
    .byte_stream (byte_if),
    .char_stream (char_if)
  );

  // Decoder state mirrored by the bench
  logic [1:0]      lead_pending = '0;
  logic [CP_W-1:0] acc_cp       = '0;
  logic            str_done     = 1'b0;

  result_t    byte_chars_q[$];
  result_t    chars_due_q[$];
  logic [8:0] buf_q[$];
  stim_row_t  dir_tab [0:N_DIRECTED-1];

  int   n_err    = 0;
  int   n_rx     = 0;
  int   n_live   = 0;
  logic tx_burst = 1'b0;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic stim_row_t mk_row(input logic [7:0] b, input logic last,
                                       input logic fixed, input logic [1:0] nres,
                                       input result_t r0, input result_t r1);
    return {b, last, fixed, nres, r0, r1};
  endfunction

  function automatic void note_char(input logic [CP_W-1:0] cp, input logic em);
    byte_chars_q.push_back({cp, em, 1'b0});
  endfunction

  // Work out the characters one byte gives, and advance the mirrored state
  function automatic void decode_byte(input logic [7:0] b, input logic last);
    result_t tail;
    logic    zero_start;
    byte_chars_q.delete();
    zero_start = (lead_pending == 2'd0) && (b == 8'h00);
    // Drop everything after a terminator; the final byte re-arms
    if (str_done) begin
      if (last) begin
        lead_pending = '0;
        acc_cp       = '0;
        str_done     = 1'b0;
      end
      return;
    end
    if (lead_pending != 2'd0) begin
      acc_cp       = {acc_cp[CP_W-7:0], b[5:0]};
      lead_pending = lead_pending - 2'd1;
      if (lead_pending == 2'd0)
        note_char(acc_cp, 1'b0);
      else if (last)
        note_char(REPLACEMENT_CHAR, 1'b0);
    end else if (zero_start) begin
      note_char(END_CODE, 1'b1);
      if (last)
        acc_cp = '0;
      else
        str_done = 1'b1;
    end else if ((b & LEAD2_MASK) == CONT_CODE) begin
      note_char(REPLACEMENT_CHAR, 1'b0);
    end else if ((b & LEAD4_MASK) == LEAD4_MASK) begin
      acc_cp       = CP_W'(b[2:0]);
      lead_pending = 2'd3;
    end else if ((b & LEAD3_MASK) == LEAD3_MASK) begin
      acc_cp       = CP_W'(b[3:0]);
      lead_pending = 2'd2;
    end else if ((b & LEAD2_MASK) == LEAD2_MASK) begin
      acc_cp       = CP_W'(b[4:0]);
      lead_pending = 2'd1;
    end else begin
      note_char(CP_W'(b), 1'b0);
    end
    // Close the buffer: flag a cut-off sequence, then the end marker
    if (last && !zero_start) begin
      if (lead_pending != 2'd0 && byte_chars_q.size() == 0)
        note_char(REPLACEMENT_CHAR, 1'b0);
      note_char(END_CODE, 1'b1);
      lead_pending = '0;
      acc_cp       = '0;
      str_done     = 1'b0;
    end
    if (byte_chars_q.size() > 0) begin
      tail           = byte_chars_q.pop_back();
      tail.run_final = 1'b1;
      byte_chars_q.push_back(tail);
    end
  endfunction

  function automatic logic [7:0] lead_of(input int len);
    case (len)
      1:       return 8'($urandom_range(1, 127));
      2:       return LEAD2_MASK | 8'($urandom_range(0, 31));
      3:       return LEAD3_MASK | 8'($urandom_range(0, 15));
      default: return LEAD4_MASK | 8'($urandom_range(0, 15));
    endcase
  endfunction

  // Mostly proper continuation bytes, now and then anything at all
  function automatic logic [7:0] follow_byte();
    if ($urandom_range(0, 7) == 0)
      return 8'($urandom_range(0, 255));
    return CONT_CODE | 8'($urandom_range(0, 63));
  endfunction

  // Fill buf_q with one buffer: well-formed characters, at times cut off or ended by a zero, or raw noise
  task automatic build_buffer();
    int         mode;
    int         len;
    logic [8:0] fin;
    buf_q.delete();
    mode = $urandom_range(0, 9);
    if (mode < 7) begin
      repeat ($urandom_range(1, 6)) begin
        len = $urandom_range(1, 4);
        buf_q.push_back({1'b0, lead_of(len)});
        repeat (len - 1) buf_q.push_back({1'b0, follow_byte()});
      end
      case ($urandom_range(0, 7))
        0: begin
          len = $urandom_range(2, 4);
          buf_q.push_back({1'b0, lead_of(len)});
          repeat ($urandom_range(0, len - 2)) buf_q.push_back({1'b0, follow_byte()});
        end
        1: begin
          buf_q.push_back(9'h000);
          repeat ($urandom_range(0, 3)) buf_q.push_back({1'b0, 8'($urandom_range(0, 255))});
        end
        default: ;
      endcase
    end else begin
      repeat ($urandom_range(1, 8))
        buf_q.push_back({($urandom_range(0, 7) == 0), 8'($urandom_range(0, 255))});
    end
    fin = buf_q.pop_back();
    fin[8] = (mode < 7) ? 1'b1 : 1'($urandom_range(0, 1));
    buf_q.push_back(fin);
  endtask

  // Offer one byte after a random gap; predict once it is taken
  task automatic send_byte(input logic [7:0] b, input logic last, input logic fixed,
                           input logic [1:0] nres, input result_t r0, input result_t r1);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
    if ($urandom_range(0, 31) == 0)
      tx_burst = ~tx_burst;
    if (gap > 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_if.valid       <= 1'b1;
    byte_if.data_byte   <= b;
    byte_if.buffer_last <= last;
    @(posedge clk);
    while (!byte_if.ready) @(posedge clk);
    if (!str_done)
      n_live++;
    decode_byte(b, last);
    if (fixed) begin
      if (nres != NRES_NONE)
        chars_due_q.push_back(r0);
      if (nres == NRES_TWO)
        chars_due_q.push_back(r1);
    end else begin
      foreach (byte_chars_q[k]) chars_due_q.push_back(byte_chars_q[k]);
    end
  endtask

  // Stimulus: reset, directed table, random buffers, drain
  initial begin
    logic [8:0] item;
    logic       tx_paused;
    tx_paused            = 1'b0;
    rst                 <= 1'b1;
    byte_if.valid       <= 1'b0;
    byte_if.data_byte   <= '0;
    byte_if.buffer_last <= 1'b0;

    // ASCII bytes, the top ASCII value and stray continuation bytes
    dir_tab[0]  = mk_row(8'h41, 1'b0, 1'b1, NRES_ONE, {21'h000041, 1'b0, 1'b1}, NO_CHAR);
    dir_tab[1]  = mk_row(8'h7F, 1'b0, 1'b1, NRES_ONE, {21'h00007F, 1'b0, 1'b1}, NO_CHAR);
    dir_tab[2]  = mk_row(8'h80, 1'b0, 1'b1, NRES_ONE, {REPLACEMENT_CHAR, 1'b0, 1'b1}, NO_CHAR);
    dir_tab[3]  = mk_row(8'hBF, 1'b0, 1'b1, NRES_ONE, {REPLACEMENT_CHAR, 1'b0, 1'b1}, NO_CHAR);
    // Two-, three- and four-byte characters
    dir_tab[4]  = mk_row(8'hC2, 1'b0, 1'b1, NRES_NONE, NO_CHAR, NO_CHAR);
    dir_tab[5]  = mk_row(8'hA9, 1'b0, 1'b0, NRES_NONE, NO_CHAR, NO_CHAR);
    dir_tab[6]  = mk_row(8'hE2, 1'b0, 1'b1, NRES_NONE, NO_CHAR, NO_CHAR);
    dir_tab[7]  = mk_row(8'h82, 1'b0, 1'b0, NRES_NONE, NO_CHAR, NO_CHAR);
    dir_tab[8]  = mk_row(8'hAC, 1'b0, 1'b0, NRES_NONE, NO_CHAR, NO_CHAR);
    dir_tab[9]  = mk_row(8'hF0, 1'b0, 1'b1, NRES_NONE, NO_CHAR, NO_CHAR);
    dir_tab[10] = mk_row(8'h9F, 1'b0, 1'b0, NRES_NONE, NO_CHAR, NO_CHAR);
    dir_tab[11] = mk_row(8'h98, 1'b0, 1'b0, NRES_NONE, NO_CHAR, NO_CHAR);
    dir_tab[12] = mk_row(8'h80, 1'b0, 1'b0, NRES_NONE, NO_CHAR, NO_CHAR);
    // All ones: the widest code point
    dir_tab[13] = mk_row(8'hFF, 1'b0, 1'b1, NRES_NONE, NO_CHAR, NO_CHAR);
    dir_tab[14] = mk_row(8'hFF, 1'b0, 1'b0, NRES_NONE, NO_CHAR, NO_CHAR);
    dir_tab[15] = mk_row(8'hFF, 1'b0, 1'b0, NRES_NONE, NO_CHAR, NO_CHAR);
    dir_tab[16] = mk_row(8'hFF, 1'b0, 1'b0, NRES_NONE, NO_CHAR, NO_CHAR);
    // Sequence cut off by the final byte
    dir_tab[17] = mk_row(8'hC3, 1'b1, 1'b1, NRES_TWO, {REPLACEMENT_CHAR, 1'b0, 1'b0},
                         {END_CODE, 1'b1, 1'b1});
    // Terminator, ignored bytes, re-arm on the final byte
    dir_tab[18] = mk_row(8'h00, 1'b0, 1'b1, NRES_ONE, {END_CODE, 1'b1, 1'b1}, NO_CHAR);
    dir_tab[19] = mk_row(8'h41, 1'b0, 1'b1, NRES_NONE, NO_CHAR, NO_CHAR);
    dir_tab[20] = mk_row(8'hFF, 1'b1, 1'b1, NRES_NONE, NO_CHAR, NO_CHAR);
    // Zero bytes as continuation, completed by the final byte
    dir_tab[21] = mk_row(8'hE0, 1'b0, 1'b1, NRES_NONE, NO_CHAR, NO_CHAR);
    dir_tab[22] = mk_row(8'h00, 1'b0, 1'b0, NRES_NONE, NO_CHAR, NO_CHAR);
    dir_tab[23] = mk_row(8'h00, 1'b1, 1'b0, NRES_NONE, NO_CHAR, NO_CHAR);
    // Zero as the final byte, character plus end marker on one byte
    dir_tab[24] = mk_row(8'h00, 1'b1, 1'b1, NRES_ONE, {END_CODE, 1'b1, 1'b1}, NO_CHAR);
    dir_tab[25] = mk_row(8'h41, 1'b1, 1'b1, NRES_TWO, {21'h000041, 1'b0, 1'b0},
                         {END_CODE, 1'b1, 1'b1});

    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i])
      send_byte(dir_tab[i].data_byte, dir_tab[i].buffer_last, dir_tab[i].fixed,
                dir_tab[i].nres, dir_tab[i].r0, dir_tab[i].r1);

    n_live = 0;
    while (n_live < RANDOM_ITEMS) begin
      build_buffer();
      while (buf_q.size() > 0) begin
        item = buf_q.pop_front();
        send_byte(item[7:0], item[8], 1'b0, NRES_NONE, NO_CHAR, NO_CHAR);
      end
      // Halfway through, hold off until the block has emptied
      if (!tx_paused && n_live >= RANDOM_ITEMS / 2) begin
        tx_paused      = 1'b1;
        byte_if.valid <= 1'b0;
        @(posedge clk);
        while (chars_due_q.size() != 0) @(posedge clk);
      end
    end
    byte_if.valid <= 1'b0;

    while (chars_due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_err == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // Result side: random stalls, one long hold, compare with the oldest due
  initial begin
    int      gap;
    result_t got;
    result_t want;
    logic    rx_burst;
    logic    rx_held;
    rx_burst       = 1'b0;
    rx_held        = 1'b0;
    char_if.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      gap = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      if ($urandom_range(0, 31) == 0)
        rx_burst = ~rx_burst;
      if (!rx_held && n_rx >= HOLD_AFTER) begin
        rx_held = 1'b1;
        gap     = LONG_HOLD;
      end
      if (gap > 0) begin
        char_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      char_if.ready <= 1'b1;
      @(posedge clk);
      while (!char_if.valid) @(posedge clk);
      got = {char_if.code_point, char_if.end_marker, char_if.run_final};
      n_rx++;
      if (chars_due_q.size() == 0) begin
        $error("unexpected result: code_point %h end_marker %b run_final %b",
               got.code_point, got.end_marker, got.run_final);
        n_err++;
      end else begin
        want = chars_due_q.pop_front();
        if (got.code_point !== want.code_point) begin
          $error("code_point: expected %h, got %h", want.code_point, got.code_point);
          n_err++;
        end
        if (got.end_marker !== want.end_marker) begin
          $error("end_marker: expected %b, got %b", want.end_marker, got.end_marker);
          n_err++;
        end
        if (got.run_final !== want.run_final) begin
          $error("run_final: expected %b, got %b", want.run_final, got.run_final);
          n_err++;
        end
      end
    end
  end

endmodule

// File: sim.f
hw/rtl/u8d_pkg.sv
hw/rtl/u8d_in_if.sv
hw/rtl/u8d_out_if.sv
hw/rtl/u8d_decode.sv
hw/rtl/u8d_result_fifo.sv
hw/rtl/utf8_byte_stream_decoder.sv
hw/rtl/u8d_checker.sv
sim/tb_utf8_byte_stream_decoder.sv
